// File: hdl/temporal_pixel_blend_defines.svh
// Assertion macros shared by the temporal pixel blend RTL.
`ifndef TEMPORAL_PIXEL_BLEND_DEFINES_SVH
`define TEMPORAL_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("temporal pixel blend check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("temporal pixel blend check failed");

`endif

// File: hdl/tpb_pkg.sv
// Package with the shared types, constants and helpers of the temporal pixel blend.
package tpb_pkg;

  localparam int PIXEL_COUNT = 256;
  localparam int POS_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int LANES       = 3;
  localparam int CHAN_W      = 8;
  localparam int WORD_W      = LANES * CHAN_W;
  localparam int WEIGHT_W    = 9;
  localparam int MODES       = 12;
  localparam int MODE_W      = 4;

  localparam logic [MODE_W-1:0]   MODE_LIMIT   = 4'd11;
  localparam logic [MODE_W-1:0]   MODE_DEFAULT = 4'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd97;
  localparam logic [MODES-1:0]    MASK_RESET   = 12'd2029;

  // Configuration register indexes, decoded from paddr[2].
  localparam int  ADDR_W           = 3;
  localparam logic REG_BLEND_WEIGHT = 1'b0;
  localparam logic REG_MODE_MASK    = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    logic smooth;
    logic standby;
  } lane_ctrl_t;

  // Out-of-range modes act as the default mode.
  function automatic logic mode_smoothed(input logic [MODES-1:0] mask,
                                         input logic [MODE_W-1:0] mode);
    logic [MODE_W-1:0] eff;
    eff = (mode > MODE_LIMIT) ? MODE_DEFAULT : mode;
    return mask[eff];
  endfunction

endpackage

// File: hdl/tpb_if.sv
// Stream interfaces for pixel beats into and out of the temporal pixel blend.
interface tpb_in_if;
  logic                     valid;
  logic                     ready;
  logic [tpb_pkg::CHAN_W-1:0] red_in;
  logic [tpb_pkg::CHAN_W-1:0] green_in;
  logic [tpb_pkg::CHAN_W-1:0] blue_in;
  logic [tpb_pkg::MODE_W-1:0] mode_number;
  logic                     standby;
  logic                     last_pixel;

  modport source (output valid, red_in, green_in, blue_in, mode_number, standby, last_pixel,
                  input ready);
  modport sink (input valid, red_in, green_in, blue_in, mode_number, standby, last_pixel,
                output ready);
endinterface

interface tpb_out_if;
  logic                     valid;
  logic                     ready;
  logic [tpb_pkg::CHAN_W-1:0] red_out;
  logic [tpb_pkg::CHAN_W-1:0] green_out;
  logic [tpb_pkg::CHAN_W-1:0] blue_out;
  logic                     last_out;

  modport source (output valid, red_out, green_out, blue_out, last_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, last_out, output ready);
endinterface

// File: hdl/tpb_ram.sv
// Generic single-write, single-read RAM with a registered, read-first output.
module tpb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/tpb_lane.sv
// One color lane: blends a channel toward its history value, or passes or blanks it.
module tpb_lane (
  input  tpb_pkg::chan_t                 prev,
  input  tpb_pkg::chan_t                 cur,
  input  logic [tpb_pkg::WEIGHT_W-1:0]   weight,
  input  tpb_pkg::lane_ctrl_t            ctrl,
  output tpb_pkg::chan_t                 res
);

  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic signed [9:0]  step;
  logic signed [10:0] sum;
  tpb_pkg::chan_t     blended;

  // The arithmetic shift of the product floors toward minus infinity.
  always_comb begin
    diff = $signed({1'b0, cur}) - $signed({1'b0, prev});
    prod = 18'(diff) * $signed({9'd0, weight});
    step = prod[17:8];
    sum  = $signed({3'b000, prev}) + 11'(step);
    if (sum < 0) begin
      blended = '0;
    end else if (sum > 11'sd255) begin
      blended = '1;
    end else begin
      blended = sum[7:0];
    end
  end

  always_comb begin
    if (ctrl.standby) begin
      res = '0;
    end else if (ctrl.smooth) begin
      res = blended;
    end else begin
      res = cur;
    end
  end

endmodule

// File: hdl/temporal_pixel_blend.sv
// Top level of the temporal pixel blend: frame-history smoothing of an RGB pixel stream.
// The block takes one pixel beat per clock while the output is free and gives one result
// beat per pixel; a stalled output holds back the pipeline without losing a beat. The rate
// is set by the frame memory, one read and one write port used once per pixel; a pixel
// reads its history on entry (registered) and is blended in the three color lanes from the
// lane stage register before landing in the output register. A pixel in a smoothed mode
// with valid history becomes prev + floor((new - prev) * w / 256) per channel, saturated to
// 0..255, where w is the blend_weight register (Q1.8, reset 97). The first frame after
// invalid history, and modes whose bit is clear in smoothing_mode_mask, pass through raw;
// standby forces black. Mode numbers above 11 act as mode 0. Every output pixel is written
// back as history for its frame position. The history flag changes only on a last-pixel
// beat, so a frame starts smoothing only after a frame whose last beat was not standby. The
// frame memory needs no clearing pass after reset; its entries are not read for smoothing
// before they have been written. The user must write configuration over the APB port only
// while no pixel is in flight; the block itself does not enforce this.
module temporal_pixel_blend (
  input  logic                        clk,
  input  logic                        rst,
  tpb_in_if.sink                      pixel_in,
  tpb_out_if.source                   pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpb_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

`include "temporal_pixel_blend_defines.svh"

  // Configuration registers.
  logic [tpb_pkg::WEIGHT_W-1:0] blend_weight;
  logic [tpb_pkg::MODES-1:0]    smoothing_mode_mask;
  logic                         cfg_write;

  // Frame tracking.
  tpb_pkg::pos_t pixel_position;
  tpb_pkg::pos_t pixel_position_next;
  logic          history_valid;

  // Lane stage registers.
  logic                  s1_valid;
  tpb_pkg::pos_t         s1_pos;
  tpb_pkg::chan_t        s1_chan [tpb_pkg::LANES];
  tpb_pkg::lane_ctrl_t   s1_ctrl;
  logic                  s1_last;
  logic                  fwd_hit;
  logic [tpb_pkg::WORD_W-1:0] fwd_data;

  // Output register.
  logic           out_valid;
  tpb_pkg::chan_t out_chan [tpb_pkg::LANES];
  logic           out_last;

  logic                       in_fire;
  logic                       s1_go;
  logic                       in_smooth;
  logic [tpb_pkg::WORD_W-1:0] ram_rdata;
  logic [tpb_pkg::WORD_W-1:0] prev_word;
  logic [tpb_pkg::WORD_W-1:0] merged;
  tpb_pkg::chan_t             lane_res [tpb_pkg::LANES];

  // APB: zero-wait-state writes; reads return the register contents.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight        <= tpb_pkg::WEIGHT_RESET;
      smoothing_mode_mask <= tpb_pkg::MASK_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        tpb_pkg::REG_BLEND_WEIGHT: blend_weight        <= pwdata[tpb_pkg::WEIGHT_W-1:0];
        tpb_pkg::REG_MODE_MASK:    smoothing_mode_mask <= pwdata[tpb_pkg::MODES-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tpb_pkg::REG_BLEND_WEIGHT: prdata = 32'(blend_weight);
      tpb_pkg::REG_MODE_MASK:    prdata = 32'(smoothing_mode_mask);
      default:                   prdata = '0;
    endcase
  end

  // Handshake. The lane stage moves on when the output register is empty or being drained;
  // a new beat enters whenever the lane stage is empty or moving on in the same cycle.
  assign s1_go          = s1_valid && (!out_valid || pixel_out.ready);
  assign pixel_in.ready = !s1_valid || s1_go;
  assign in_fire        = pixel_in.valid && pixel_in.ready;

  // The smoothing decision is made on entry, against the history flag left by earlier beats.
  assign in_smooth = history_valid &&
                     tpb_pkg::mode_smoothed(smoothing_mode_mask, pixel_in.mode_number);

  always_comb begin
    if (pixel_in.last_pixel || pixel_position == tpb_pkg::POS_W'(tpb_pkg::PIXEL_COUNT - 1)) begin
      pixel_position_next = '0;
    end else begin
      pixel_position_next = pixel_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      history_valid  <= 1'b0;
    end else if (in_fire) begin
      pixel_position <= pixel_position_next;
      if (pixel_in.last_pixel) begin
        history_valid <= !pixel_in.standby;
      end
    end
  end

  // Frame memory: read on entry, written when the pixel leaves the lane stage.
  tpb_ram #(
    .WIDTH (tpb_pkg::WORD_W),
    .DEPTH (tpb_pkg::PIXEL_COUNT)
  ) u_frame_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_pos),
    .wdata (merged),
    .re    (in_fire),
    .raddr (pixel_position),
    .rdata (ram_rdata)
  );

  // The memory reads before it writes, so a beat entering on the same edge that its own
  // position is written (single-pixel frames) takes the written word from the bypass.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_go && (s1_pos == pixel_position);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
        fwd_hit  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos          <= pixel_position;
      s1_chan[0]      <= pixel_in.red_in;
      s1_chan[1]      <= pixel_in.green_in;
      s1_chan[2]      <= pixel_in.blue_in;
      s1_ctrl.smooth  <= in_smooth;
      s1_ctrl.standby <= pixel_in.standby;
      s1_last         <= pixel_in.last_pixel;
      fwd_data        <= merged;
    end
  end

  assign prev_word = fwd_hit ? fwd_data : ram_rdata;

  // Three color lanes; red sits in the top byte of a history word.
  for (genvar i = 0; i < tpb_pkg::LANES; i++) begin : g_lane
    localparam int HI = (tpb_pkg::LANES - i) * tpb_pkg::CHAN_W - 1;
    tpb_lane u_lane (
      .prev   (prev_word[HI -: tpb_pkg::CHAN_W]),
      .cur    (s1_chan[i]),
      .weight (blend_weight),
      .ctrl   (s1_ctrl),
      .res    (lane_res[i])
    );
  end

  // Merge the lane results into one history word.
  assign merged = {lane_res[0], lane_res[1], lane_res[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_chan <= lane_res;
      out_last <= s1_last;
    end
  end

  assign pixel_out.valid     = out_valid;
  assign pixel_out.red_out   = out_chan[0];
  assign pixel_out.green_out = out_chan[1];
  assign pixel_out.blue_out  = out_chan[2];
  assign pixel_out.last_out  = out_last;

  // A last-pixel beat always restarts the frame at position zero.
  `TPB_ASSERT_NEXT(a_last_restarts_frame, in_fire && pixel_in.last_pixel, pixel_position == '0)
  // The history flag only moves on an accepted last-pixel beat.
  `TPB_ASSERT_NEXT(a_flag_only_on_last, !(in_fire && pixel_in.last_pixel), $stable(history_valid))
  // A result beat only appears after a pixel has occupied the lane stage.
  `TPB_ASSERT_NOW(a_out_from_lane, $rose(out_valid), $past(s1_valid))
  // The bypass is only armed while a pixel sits in the lane stage.
  `TPB_ASSERT_NOW(a_bypass_with_pixel, fwd_hit, s1_valid)

endmodule
